@@ rtl/adcd_pkg.sv @@
// adcd_pkg: shared types and constants of the converter clock divider solver
// used by adcd_div, adcd_ctrl and adc_clock_divider_solver; no dependencies
`default_nettype none

package adcd_pkg;

    localparam int PB_W   = 28;
    localparam int RATE_W = 24;
    localparam int DVS_W  = 30;
    localparam int QUO_W  = PB_W;

    localparam logic [RATE_W-1:0] RATE_LIMIT     = 24'd1000000;
    localparam logic [7:0]        DIV_LAST       = 8'd255;
    localparam logic [4:0]        ST_SAT         = 5'd31;
    localparam logic [QUO_W-1:0]  RATE_FIELD_MAX = 28'd16777215;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TOO_LARGE   = 3'd1,
        ST_NOT_PB      = 3'd2,
        ST_NO_SOLUTION = 3'd3,
        ST_ZERO_RATE   = 3'd4
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [7:0]        clock_divider;
        logic [4:0]        sample_time;
        logic [RATE_W-1:0] achieved_rate_hz;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ rtl/adcd_div.sv @@
// adcd_div: shared restoring divider, one quotient bit per cycle
// depends on adcd_pkg
`default_nettype none

module adcd_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [adcd_pkg::PB_W-1:0]   i_dividend,
    input  wire adcd_pkg::t_div_req          i_req,
    output adcd_pkg::t_div_rsp               o_rsp
);
    import adcd_pkg::*;

    localparam int CntW = $clog2(QUO_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CntW-1:0]      r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_dvs;

    logic [DVS_W:0]       w_shift;
    logic [DVS_W:0]       w_diff;

    assign w_shift = {r_rem, r_quo[QUO_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CntW'(1);
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[DVS_W]) begin
                r_rem <= w_diff[DVS_W-1:0];
            end else begin
                r_rem <= w_shift[DVS_W-1:0];
            end
            r_quo <= {r_quo[QUO_W-2:0], ~w_diff[DVS_W]};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

@@ rtl/adcd_ctrl.sv @@
// adcd_ctrl: sequencer of divider and sample time search, result register
// depends on adcd_pkg; drives adcd_div through t_div_req / t_div_rsp
`default_nettype none

module adcd_ctrl #(
    parameter int TAD_FREQ_MAX    = 15000000,
    parameter int CONV_TIME       = 12,
    parameter int SAMPLE_TIME_MAX = 32,
    parameter int SAMPLE_RATE_MAX = 1000000
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clock_is_pb,
    input  wire logic                          i_req_valid,
    output logic                               o_req_stall,
    input  wire logic [adcd_pkg::RATE_W-1:0]   i_sample_rate_hz,
    output adcd_pkg::t_div_req                 o_div_req,
    input  wire adcd_pkg::t_div_rsp            i_div_rsp,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_stall,
    output adcd_pkg::t_result                  o_result
);
    import adcd_pkg::*;

    localparam logic [QUO_W-1:0] TadMax = QUO_W'(TAD_FREQ_MAX);
    localparam logic [QUO_W-1:0] SrMax  = QUO_W'(SAMPLE_RATE_MAX);
    localparam logic [8:0]       StMax  = 9'(SAMPLE_TIME_MAX);
    localparam logic [5:0]       ConvW  = 6'(CONV_TIME);
    localparam logic [7:0]       Conv8  = 8'(CONV_TIME);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MIN    = 7'b0000010,
        S_CHK    = 7'b0000100,
        S_SRCH_Q = 7'b0001000,
        S_SRCH_T = 7'b0010000,
        S_RATE   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic [7:0]          r_div, n_div;
    logic [9:0]          r_d, n_d;
    logic [DVS_W-1:0]    r_rd, n_rd;
    logic [7:0]          r_st8, n_st8;
    logic [4:0]          r_st, n_st;
    t_result             r_res, n_res;
    logic                r_start, n_start;
    logic [DVS_W-1:0]    r_divisor, n_divisor;
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [QUO_W-1:0]    w_q;
    logic [QUO_W-1:0]    w_q_sat;
    logic [DVS_W-1:0]    w_two_rate;
    logic [7:0]          w_st_next;
    logic [4:0]          w_st_sat;
    logic [4:0]          w_mul_st;
    logic [15:0]         w_prod;
    logic                v_fail;

    assign w_q        = i_div_rsp.quot;
    assign w_q_sat    = (w_q > RATE_FIELD_MAX) ? RATE_FIELD_MAX : w_q;
    assign w_two_rate = {5'b0, r_rate, 1'b0};
    assign w_st_next  = w_q[7:0] - Conv8;
    assign w_st_sat   = (r_st8 > 8'(ST_SAT)) ? ST_SAT : r_st8[4:0];

    always_comb begin
        case (r_state)
            S_MIN:    w_mul_st = 5'd1;
            S_SRCH_T: w_mul_st = w_st_sat;
            default:  w_mul_st = r_st + 5'd1;
        endcase
    end

    assign w_prod = 16'(r_d) * 16'(ConvW + {1'b0, w_mul_st});

    always_comb begin
        n_state     = r_state;
        n_rate      = r_rate;
        n_div       = r_div;
        n_d         = r_d;
        n_rd        = r_rd;
        n_st8       = r_st8;
        n_st        = r_st;
        n_res       = r_res;
        n_start     = 1'b0;
        n_divisor   = r_divisor;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        v_fail      = 1'b0;

        if (r_out_valid && !i_rsp_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_rate = i_sample_rate_hz;
                    n_div  = '0;
                    n_d    = 10'd2;
                    n_rd   = {5'b0, i_sample_rate_hz, 1'b0};
                    n_res  = '0;
                    if (i_sample_rate_hz > RATE_LIMIT) begin
                        n_res.status = ST_TOO_LARGE;
                        n_state      = S_DONE;
                    end else if (!i_clock_is_pb) begin
                        n_res.status = ST_NOT_PB;
                        n_state      = S_DONE;
                    end else if (i_sample_rate_hz == '0) begin
                        n_res.status = ST_ZERO_RATE;
                        n_state      = S_DONE;
                    end else begin
                        n_state   = S_MIN;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(2);
                    end
                end
            end
            S_MIN: begin
                if (i_div_rsp.done) begin
                    if (r_div != DIV_LAST && w_q > TadMax) begin
                        n_div     = r_div + 8'd1;
                        n_d       = r_d + 10'd2;
                        n_rd      = r_rd + w_two_rate;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(r_d + 10'd2);
                    end else begin
                        n_state   = S_CHK;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(w_prod);
                    end
                end
            end
            S_CHK: begin
                if (i_div_rsp.done) begin
                    if (w_q < QUO_W'(r_rate)) begin
                        n_res.status = ST_TOO_LARGE;
                        n_state      = S_DONE;
                    end else begin
                        n_state   = S_SRCH_Q;
                        n_start   = 1'b1;
                        n_divisor = r_rd;
                    end
                end
            end
            S_SRCH_Q: begin
                if (i_div_rsp.done) begin
                    n_st8 = w_st_next;
                    if ({1'b0, w_st_next} < StMax) begin
                        n_state   = S_SRCH_T;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(r_d);
                    end else begin
                        v_fail = 1'b1;
                    end
                end
            end
            S_SRCH_T: begin
                if (i_div_rsp.done) begin
                    if (w_q < TadMax) begin
                        n_st      = w_st_sat;
                        n_state   = S_RATE;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(w_prod);
                    end else begin
                        v_fail = 1'b1;
                    end
                end
            end
            S_RATE: begin
                if (i_div_rsp.done) begin
                    if (r_st != ST_SAT && w_q_sat > SrMax) begin
                        n_st      = r_st + 5'd1;
                        n_start   = 1'b1;
                        n_divisor = DVS_W'(w_prod);
                    end else begin
                        n_res.status        = ST_OK;
                        n_res.clock_divider = r_div;
                        n_res.sample_time   = r_st;
                        n_res.achieved_rate_hz = w_q_sat[RATE_W-1:0];
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_rsp_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // next divider trial, or give up at the last divider
        if (v_fail) begin
            if (r_div == DIV_LAST) begin
                n_res.status = ST_NO_SOLUTION;
                n_state      = S_DONE;
            end else begin
                n_div     = r_div + 8'd1;
                n_d       = r_d + 10'd2;
                n_rd      = r_rd + w_two_rate;
                n_state   = S_SRCH_Q;
                n_start   = 1'b1;
                n_divisor = r_rd + w_two_rate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate    <= n_rate;
        r_div     <= n_div;
        r_d       <= n_d;
        r_rd      <= n_rd;
        r_st8     <= n_st8;
        r_st      <= n_st;
        r_res     <= n_res;
        r_divisor <= n_divisor;
        r_out     <= n_out;
    end

    assign o_req_stall       = (r_state != S_IDLE);
    assign o_div_req.start   = r_start;
    assign o_div_req.divisor = r_divisor;
    assign o_rsp_valid       = r_out_valid;
    assign o_result          = r_out;

`ifndef SYNTHESIS
    a_d_tracks_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_d == {({1'b0, r_div} + 9'd1), 1'b0}))
        else $error("divisor step out of step with divider value");

    a_rd_tracks_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_rd == DVS_W'(r_rate) * DVS_W'(r_d)))
        else $error("rate product out of step with divider value");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |->
            (r_out.clock_divider == '0 && r_out.sample_time == '0 &&
             r_out.achieved_rate_hz == '0))
        else $error("error result carries nonzero fields");

    a_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |->
            (r_state == S_MIN || r_state == S_CHK || r_state == S_SRCH_Q ||
             r_state == S_SRCH_T || r_state == S_RATE))
        else $error("division finished outside a division step");
`endif

endmodule

`default_nettype wire

@@ rtl/adc_clock_divider_solver.sv @@
// adc_clock_divider_solver: top level, register port, sequencer and shared divider
// a request rejected on its rate or clock source runs no division; a solved request
//   runs divisions for the min divider search, one feasibility check, one or two per
//   divider trial and one per sample time step
// throughput: one request in flight, set by the single shared divider
// reset: synchronous active low, pb_clock_hz = 40000000 and clock_is_pb = 1
`default_nettype none

module adc_clock_divider_solver #(
    parameter int TAD_FREQ_MAX    = 15000000,
    parameter int CONV_TIME       = 12,
    parameter int SAMPLE_TIME_MAX = 32,
    parameter int SAMPLE_RATE_MAX = 1000000
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          i_req_valid,
    output logic                               o_req_stall,
    input  wire logic [adcd_pkg::RATE_W-1:0]   i_sample_rate_hz,
    output logic                               o_rsp_valid,
    input  wire logic                          i_rsp_stall,
    output logic [2:0]                         o_status,
    output logic [7:0]                         o_clock_divider,
    output logic [4:0]                         o_sample_time,
    output logic [adcd_pkg::RATE_W-1:0]        o_achieved_rate_hz
);
    import adcd_pkg::*;

    localparam logic REG_PB_CLOCK = 1'b0;
    localparam logic REG_CLK_IS_PB = 1'b1;

    logic [PB_W-1:0]  r_pb_clock_hz;
    logic             r_clock_is_pb;
    logic             w_wr;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;
    t_result          w_result;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pb_clock_hz <= 28'd40000000;
            r_clock_is_pb <= 1'b1;
        end else if (w_wr) begin
            case (paddr[2])
                REG_PB_CLOCK:  r_pb_clock_hz <= pwdata[PB_W-1:0];
                REG_CLK_IS_PB: r_clock_is_pb <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_PB_CLOCK:  prdata = {4'b0, r_pb_clock_hz};
            REG_CLK_IS_PB: prdata = {31'b0, r_clock_is_pb};
            default:       prdata = '0;
        endcase
    end

    adcd_ctrl #(
        .TAD_FREQ_MAX    (TAD_FREQ_MAX),
        .CONV_TIME       (CONV_TIME),
        .SAMPLE_TIME_MAX (SAMPLE_TIME_MAX),
        .SAMPLE_RATE_MAX (SAMPLE_RATE_MAX)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_clock_is_pb    (r_clock_is_pb),
        .i_req_valid      (i_req_valid),
        .o_req_stall      (o_req_stall),
        .i_sample_rate_hz (i_sample_rate_hz),
        .o_div_req        (w_div_req),
        .i_div_rsp        (w_div_rsp),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_stall      (i_rsp_stall),
        .o_result         (w_result)
    );

    adcd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dividend (r_pb_clock_hz),
        .i_req      (w_div_req),
        .o_rsp      (w_div_rsp)
    );

    assign o_status           = w_result.status;
    assign o_clock_divider    = w_result.clock_divider;
    assign o_sample_time      = w_result.sample_time;
    assign o_achieved_rate_hz = w_result.achieved_rate_hz;

endmodule

`default_nettype wire
